FILE: rtl/core/fbfl_pkg.sv
// Shared types, constants and codes of the fixed block free list allocator.
package fbfl_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int OP_W    = 1;
  localparam int BIDX_W  = 8;
  localparam int NB_W    = 9;
  localparam int SIZE_W  = 17;
  localparam int CFG_W   = 17;
  localparam int BYTES_W = 25;
  localparam int PROD_W  = CNT_W + SIZE_W;

  localparam int SIZE_MAX         = 65536;
  localparam int RESET_NUM_BLOCKS = 256;
  localparam int RESET_BLOCK_SIZE = 64;
  localparam int RESET_COUNT      = (RESET_NUM_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS
                                                                    : RESET_NUM_BLOCKS;
  localparam logic [BYTES_W-1:0] BYTES_SAT = {BYTES_W{1'b1}};

  localparam logic [0:0] REG_NUM_BLOCKS = 1'b0;
  localparam logic [0:0] REG_BLOCK_SIZE = 1'b1;

  localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] idx;
  } list_req_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   granted;
    logic [CNT_W-1:0]   free_count;
  } list_res_t;

endpackage

FILE: rtl/core/fbfl_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/fbfl_list.sv
// Free list sequencer: head, free count, link memory with per-entry valid bits.
module fbfl_list (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rebuild,
  input  logic                       start,
  input  fbfl_pkg::list_req_t        req,
  input  logic [fbfl_pkg::CNT_W-1:0] nb,
  output logic                       idle,
  output logic                       res_valid,
  output fbfl_pkg::list_res_t        res
);

  typedef enum logic {IDLE, FETCH} state_t;

  state_t                                state;
  logic [fbfl_pkg::IDX_W-1:0]            head;
  logic [fbfl_pkg::IDX_W-1:0]            granted;
  logic [fbfl_pkg::CNT_W-1:0]            count;
  logic [fbfl_pkg::MAX_BLOCKS-1:0]       valid;
  logic                                  rd_vbit;
  logic [fbfl_pkg::IDX_W-1:0]            rdata;
  logic [fbfl_pkg::IDX_W-1:0]            widx;
  logic [fbfl_pkg::IDX_W-1:0]            seq_next;
  logic                                  is_alloc;
  logic                                  in_range;
  logic                                  push;
  logic                                  pop;

  assign is_alloc = (req.op == fbfl_pkg::OP_ALLOC);
  assign in_range = (32'(req.idx) < 32'(nb));
  assign widx     = fbfl_pkg::IDX_W'(req.idx);
  assign pop      = start && (state == IDLE) && is_alloc && (count != '0);
  assign push     = start && (state == IDLE) && !is_alloc && in_range && (count < nb);
  assign idle     = (state == IDLE);

  // untouched entries (valid bit clear) follow the initial chain i -> i+1, wrapping to 0
  assign seq_next = (granted == fbfl_pkg::IDX_W'(fbfl_pkg::MAX_BLOCKS - 1)) ? '0
                                                                           : granted + 1'b1;

  // reads happen only for a pop and writes only for a push, never in the same item
  fbfl_ram #(
    .WIDTH(fbfl_pkg::IDX_W),
    .DEPTH(fbfl_pkg::MAX_BLOCKS)
  ) u_link (
    .clk  (clk),
    .we   (push),
    .waddr(widx),
    .wdata(head),
    .re   (pop),
    .raddr(head),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      count     <= fbfl_pkg::CNT_W'(fbfl_pkg::RESET_COUNT);
      valid     <= '0;
      res_valid <= 1'b0;
    end else if (rebuild) begin
      state     <= IDLE;
      head      <= '0;
      count     <= nb;
      valid     <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            if (is_alloc) begin
              if (count == '0) begin
                res_valid      <= 1'b1;
                res.status     <= fbfl_pkg::ST_EMPTY;
                res.granted    <= '0;
                res.free_count <= count;
              end else begin
                granted <= head;
                rd_vbit <= valid[head];
                count   <= count - 1'b1;
                state   <= FETCH;
              end
            end else begin
              res_valid   <= 1'b1;
              res.granted <= '0;
              priority if (!in_range) begin
                res.status     <= fbfl_pkg::ST_RANGE;
                res.free_count <= count;
              end else if (count >= nb) begin
                res.status     <= fbfl_pkg::ST_FULL;
                res.free_count <= count;
              end else begin
                valid[widx]    <= 1'b1;
                head           <= widx;
                count          <= count + 1'b1;
                res.status     <= fbfl_pkg::ST_OK;
                res.free_count <= count + 1'b1;
              end
            end
          end
        end
        FETCH: begin
          head           <= rd_vbit ? rdata : seq_next;
          res_valid      <= 1'b1;
          res.status     <= fbfl_pkg::ST_OK;
          res.granted    <= granted;
          res.free_count <= count;
          state          <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed block free list allocator: config, byte totals, output stage.
//
// Usage:
//   Requests enter on the s_ channel (operation in s_tuser, block index in s_tdata).
//   Each transaction yields exactly one result on the m_ channel with status, the
//   granted block, free count and used/free byte totals.
//   Allocate: accept to m_tvalid through the link memory read, the sequencer result
//   register, the multiply stage and the output register. Release: the same path
//   without the link memory read. s_tready returns only once the previous result
//   has left the multiply stage; the next head comes from the registered link
//   memory read, or from the i -> i+1 chain for an entry never written.
//   Configuration writes (cfg_we/cfg_index/cfg_data) must be made by the user while
//   the block is idle; the block does not enforce this. Each drops s_tready and
//   rebuilds the free list in the cycle after it. Reset restores 256 blocks of 64
//   bytes, all free, rebuilt at once via per-entry valid bits with no clearing pass.
//   When m_tready is low the result holds in the output register, one more result
//   can wait in the multiply stage and s_tready drops until space frees up.
module fixed_block_free_list_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] block_index
  input  logic [0:0]  s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // status, granted_index, free_count, used_bytes, free_bytes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic [fbfl_pkg::NB_W-1:0]    num_blocks;
  logic [fbfl_pkg::SIZE_W-1:0]  block_size;
  logic                         rebuild;
  logic [fbfl_pkg::CNT_W-1:0]   nb;
  logic [fbfl_pkg::SIZE_W-1:0]  size_eff;

  logic                         list_idle;
  logic                         list_res_valid;
  fbfl_pkg::list_res_t          list_res;
  fbfl_pkg::list_req_t          req;
  logic                         accept;

  logic                         m_valid;
  fbfl_pkg::status_t            m_status;
  logic [fbfl_pkg::IDX_W-1:0]   m_granted;
  logic [fbfl_pkg::CNT_W-1:0]   m_free;
  logic [fbfl_pkg::CNT_W-1:0]   m_used;
  logic                         m_move;

  logic [fbfl_pkg::PROD_W-1:0]  used_prod;
  logic [fbfl_pkg::PROD_W-1:0]  free_prod;
  logic [fbfl_pkg::BYTES_W-1:0] used_sat;
  logic [fbfl_pkg::BYTES_W-1:0] free_sat;

  logic                         o_valid;
  fbfl_pkg::status_t            o_status;
  logic [7:0]                   o_granted;
  logic [8:0]                   o_free;
  logic [fbfl_pkg::BYTES_W-1:0] o_used_bytes;
  logic [fbfl_pkg::BYTES_W-1:0] o_free_bytes;

  always_comb begin
    if (num_blocks == '0) begin
      nb = fbfl_pkg::CNT_W'(1);
    end else if (32'(num_blocks) > fbfl_pkg::MAX_BLOCKS) begin
      nb = fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS);
    end else begin
      nb = fbfl_pkg::CNT_W'(num_blocks);
    end
  end

  assign size_eff = (32'(block_size) > fbfl_pkg::SIZE_MAX) ?
                    fbfl_pkg::SIZE_W'(fbfl_pkg::SIZE_MAX) : block_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks <= fbfl_pkg::NB_W'(fbfl_pkg::RESET_NUM_BLOCKS);
      block_size <= fbfl_pkg::SIZE_W'(fbfl_pkg::RESET_BLOCK_SIZE);
      rebuild    <= 1'b0;
    end else begin
      rebuild <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          fbfl_pkg::REG_NUM_BLOCKS: num_blocks <= cfg_data[fbfl_pkg::NB_W-1:0];
          fbfl_pkg::REG_BLOCK_SIZE: block_size <= cfg_data[fbfl_pkg::SIZE_W-1:0];
        endcase
      end
    end
  end

  assign s_tready = list_idle && !list_res_valid && !m_valid && !rebuild;
  assign accept   = s_tvalid && s_tready;
  assign req.op   = s_tuser;
  assign req.idx  = s_tdata;

  fbfl_list u_list (
    .clk      (clk),
    .rst      (rst),
    .rebuild  (rebuild),
    .start    (accept),
    .req      (req),
    .nb       (nb),
    .idle     (list_idle),
    .res_valid(list_res_valid),
    .res      (list_res)
  );

  assign m_move    = m_valid && (!o_valid || m_tready);
  assign used_prod = fbfl_pkg::PROD_W'(m_used) * fbfl_pkg::PROD_W'(size_eff);
  assign free_prod = fbfl_pkg::PROD_W'(m_free) * fbfl_pkg::PROD_W'(size_eff);
  assign used_sat  = (used_prod > fbfl_pkg::PROD_W'(fbfl_pkg::BYTES_SAT)) ?
                     fbfl_pkg::BYTES_SAT : used_prod[fbfl_pkg::BYTES_W-1:0];
  assign free_sat  = (free_prod > fbfl_pkg::PROD_W'(fbfl_pkg::BYTES_SAT)) ?
                     fbfl_pkg::BYTES_SAT : free_prod[fbfl_pkg::BYTES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (list_res_valid) begin
        m_valid   <= 1'b1;
        m_status  <= list_res.status;
        m_granted <= list_res.granted;
        m_free    <= list_res.free_count;
        m_used    <= (nb >= list_res.free_count) ? nb - list_res.free_count : '0;
      end else if (m_move) begin
        m_valid <= 1'b0;
      end
      if (m_move) begin
        o_valid      <= 1'b1;
        o_status     <= m_status;
        o_granted    <= 8'(m_granted);
        o_free       <= 9'(m_free);
        o_used_bytes <= used_sat;
        o_free_bytes <= free_sat;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {3'b000, o_free_bytes, o_used_bytes, o_free, o_granted, o_status};

  // the sequencer never hands a result to a full multiply stage
  assert property (@(posedge clk) disable iff (rst) list_res_valid |-> !m_valid)
    else $error("list result overran the multiply stage");

  // a failed item never reports a granted block
  assert property (@(posedge clk) disable iff (rst)
    (m_valid && (m_status != fbfl_pkg::ST_OK)) |-> (m_granted == '0))
    else $error("granted index set on a failed item");

  // an accepted request always pulls s_tready low behind it
  assert property (@(posedge clk) disable iff (rst) accept |=> !s_tready)
    else $error("request accepted while the previous one is in flight");

endmodule

FILE: test/tb_fixed_block_free_list_allocator_unit.sv
// Self-checking testbench for the fixed block free list allocator unit.
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;

  typedef struct packed {
    fbfl_pkg::status_t status;
    logic [7:0]        granted;
    logic [8:0]        fcnt;
    logic [24:0]       used;
    logic [24:0]       freeb;
  } alloc_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [16:0] a;      // op or register index
    logic [16:0] b;      // block index or register data
    logic        typed;
    alloc_res_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] block_index
  logic [0:0]  s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [1:0] status, [9:2] granted_index, [18:10] free_count,
                          // [43:19] used_bytes, [68:44] free_bytes
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_data;

  fixed_block_free_list_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted pool state
  logic [7:0]  pool_link [fbfl_pkg::MAX_BLOCKS];
  logic [7:0]  pool_head;
  logic [8:0]  pool_free;
  logic [8:0]  reg_nblocks;
  logic [16:0] reg_bsize;

  alloc_res_t  pending_res [$];
  logic [7:0]  held [$];
  dir_row_t    dir_rows [$];
  int          errors;
  int          idle_cycles;
  int          tx_pct;
  int          rx_pct;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [8:0] eff_nblocks();
    if (reg_nblocks == 0) return 9'd1;
    if (reg_nblocks > fbfl_pkg::MAX_BLOCKS) return 9'(fbfl_pkg::MAX_BLOCKS);
    return reg_nblocks;
  endfunction

  function automatic logic [16:0] eff_bsize();
    if (reg_bsize > fbfl_pkg::SIZE_MAX) return 17'(fbfl_pkg::SIZE_MAX);
    return reg_bsize;
  endfunction

  function automatic logic [24:0] byte_total(input logic [8:0] n, input logic [16:0] sz);
    longint unsigned p;
    p = longint'(n) * longint'(sz);
    return (p > 64'h1FF_FFFF) ? fbfl_pkg::BYTES_SAT : p[24:0];
  endfunction

  task automatic pool_rebuild();
    for (int i = 0; i < fbfl_pkg::MAX_BLOCKS; i++) pool_link[i] = 8'(i + 1);
    pool_head = '0;
    pool_free = eff_nblocks();
  endtask

  task automatic pool_step(input logic op, input logic [7:0] idx, output alloc_res_t r);
    logic [8:0] nb;
    nb = eff_nblocks();
    r = '0;
    r.status = fbfl_pkg::ST_OK;
    if (op == fbfl_pkg::OP_ALLOC) begin
      if (pool_free == 0) begin
        r.status = fbfl_pkg::ST_EMPTY;
      end else begin
        r.granted = pool_head;
        pool_head = pool_link[pool_head];
        pool_free = pool_free - 1'b1;
      end
    end else if ({1'b0, idx} >= nb) begin
      r.status = fbfl_pkg::ST_RANGE;
    end else if (pool_free >= nb) begin
      r.status = fbfl_pkg::ST_FULL;
    end else begin
      pool_link[idx] = pool_head;
      pool_head = idx;
      pool_free = pool_free + 1'b1;
    end
    r.fcnt  = pool_free;
    r.used  = byte_total((nb >= pool_free) ? nb - pool_free : 9'd0, eff_bsize());
    r.freeb = byte_total(pool_free, eff_bsize());
  endtask

  function automatic void cmp_field(input string name, input longint unsigned e,
                                    input longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  task automatic send_item(input logic op, input logic [7:0] idx, input logic use_typed,
                           input alloc_res_t typed_res, output alloc_res_t r);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= idx;
    do @(posedge clk); while (!s_tready);
    pool_step(op, idx, r);
    pending_res.push_back(use_typed ? typed_res : r);
  endtask

  // registers change only with the pipe drained
  task automatic cfg_write(input logic [0:0] sel, input logic [16:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    if (sel == fbfl_pkg::REG_NUM_BLOCKS) reg_nblocks = data[8:0];
    else reg_bsize = data;
    pool_rebuild();
    held.delete();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [16:0] a, input logic [16:0] b,
                         input logic typed, input fbfl_pkg::status_t st, input int g,
                         input int fc, input int ub, input int fb);
    dir_row_t row;
    row.kind = kind;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.res.status = st;
    row.res.granted = 8'(g);
    row.res.fcnt = 9'(fc);
    row.res.used = 25'(ub);
    row.res.freeb = 25'(fb);
    dir_rows.push_back(row);
  endtask

  // alternating fill and drain bursts, mostly releasing blocks actually held
  task automatic random_items(input int n);
    int burst_left;
    int r;
    int k;
    logic draining;
    logic op;
    logic [7:0] idx;
    alloc_res_t res;
    burst_left = 0;
    draining = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        draining = ~draining;
        burst_left = $urandom_range(2 * int'(eff_nblocks()) + 4, 1);
      end
      burst_left--;
      r = $urandom_range(99);
      op = fbfl_pkg::OP_ALLOC;
      idx = 8'($urandom_range(255));
      if (r < 6) begin
        op = fbfl_pkg::OP_RELEASE;
      end else if (draining ? (r >= 90) : (r < 88)) begin
        op = fbfl_pkg::OP_RELEASE;
        if (held.size() != 0) begin
          k = $urandom_range(held.size() - 1);
          idx = held[k];
          held.delete(k);
        end else begin
          idx = 8'($urandom_range(int'(eff_nblocks()) - 1));
        end
      end
      send_item(op, idx, 1'b0, '0, res);
      if (op == fbfl_pkg::OP_ALLOC && res.status == fbfl_pkg::ST_OK)
        held.push_back(res.granted);
    end
  endtask

  task automatic run_phase(input logic [16:0] nb, input logic [16:0] bs, input int tx,
                           input int rx, input int n, input bit hold);
    cfg_write(fbfl_pkg::REG_NUM_BLOCKS, nb);
    cfg_write(fbfl_pkg::REG_BLOCK_SIZE, bs);
    tx_pct = tx;
    rx_pct = rx;
    if (hold) hold_req = 1'b1;
    random_items(n);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    alloc_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending_res.pop_front();
        cmp_field("status", e.status, m_tdata[1:0]);
        cmp_field("granted_index", e.granted, m_tdata[9:2]);
        cmp_field("free_count", e.fcnt, m_tdata[18:10]);
        cmp_field("used_bytes", e.used, m_tdata[43:19]);
        cmp_field("free_bytes", e.freeb, m_tdata[68:44]);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_fixed_block_free_list_allocator_unit: done, errors");
      $finish;
    end
  end

  initial begin
    alloc_res_t res;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    idle_cycles = 0;
    tx_pct    = 0;
    rx_pct    = 0;
    hold_req  = 1'b0;
    reg_nblocks = 9'(fbfl_pkg::RESET_NUM_BLOCKS);
    reg_bsize   = 17'(fbfl_pkg::RESET_BLOCK_SIZE);
    pool_rebuild();

    // reset pool: 256 blocks of 64 bytes
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 0, 255, 64, 16320);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 1, 254, 128, 16256);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 255, 1, fbfl_pkg::ST_OK, 0, 255, 64, 16320);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 255, 254, 128, 16256);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 0, 1, fbfl_pkg::ST_OK, 0, 255, 64, 16320);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 1, 1, fbfl_pkg::ST_OK, 0, 256, 0, 16384);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 255, 1, fbfl_pkg::ST_FULL, 0, 256, 0, 16384);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 0, 1, fbfl_pkg::ST_FULL, 0, 256, 0, 16384);
    add_row(ROW_CFG, fbfl_pkg::REG_NUM_BLOCKS, 4, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 4, 1, fbfl_pkg::ST_RANGE, 0, 4, 0, 256);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 255, 1, fbfl_pkg::ST_RANGE, 0, 4, 0, 256);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 3, 1, fbfl_pkg::ST_FULL, 0, 4, 0, 256);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 255, 1, fbfl_pkg::ST_OK, 0, 3, 64, 192);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 1, 2, 128, 128);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 2, 1, 192, 64);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 3, 0, 256, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_EMPTY, 0, 0, 256, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 2, 1, fbfl_pkg::ST_OK, 0, 1, 192, 64);
    // double release: same block comes out twice
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 2, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_CFG, fbfl_pkg::REG_BLOCK_SIZE, 131071, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 0, 3, 65536, 196608);
    add_row(ROW_CFG, fbfl_pkg::REG_NUM_BLOCKS, 0, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 0, 0, 65536, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_EMPTY, 0, 0, 65536, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 1, 1, fbfl_pkg::ST_RANGE, 0, 0, 65536, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 0, 1, fbfl_pkg::ST_OK, 0, 1, 0, 65536);
    add_row(ROW_ITEM, fbfl_pkg::OP_RELEASE, 0, 1, fbfl_pkg::ST_FULL, 0, 1, 0, 65536);
    add_row(ROW_CFG, fbfl_pkg::REG_BLOCK_SIZE, 0, 0, fbfl_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ROW_ITEM, fbfl_pkg::OP_ALLOC, 0, 1, fbfl_pkg::ST_OK, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        cfg_write(dir_rows[i].a[0:0], dir_rows[i].b);
      else
        send_item(dir_rows[i].a[0], dir_rows[i].b[7:0], dir_rows[i].typed,
                  dir_rows[i].res, res);
    end

    run_phase(17'd256,     17'd64,     0,  0,  300, 1'b1);
    run_phase(17'h1fe04,   17'd1,      68, 0,  150, 1'b0);
    run_phase(17'd0,       17'd65536,  0,  68, 100, 1'b0);
    run_phase(17'd1,       17'd0,      16, 16, 100, 1'b0);
    run_phase(17'd300,     17'd131071, 0,  0,  150, 1'b0);
    run_phase(17'd17,      17'd3000,   68, 0,  150, 1'b0);
    run_phase(17'd8,       17'd100,    0,  68, 150, 1'b1);
    run_phase(17'd256,     17'd65535,  16, 16, 150, 1'b0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_fixed_block_free_list_allocator_unit: done, clean");
    else
      $display("tb_fixed_block_free_list_allocator_unit: done, errors");
    $finish;
  end

endmodule
